// ----- hw/rtl/alert_tone_selector_defines.svh -----
// assertion macros used by the top rtl file
`ifndef ALERT_TONE_SELECTOR_DEFINES_SVH
`define ALERT_TONE_SELECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ATS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ATS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ats_pkg.sv -----
`default_nettype none

package ats_pkg;

  // item kinds
  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic [3:0] tone_t;

  // tone indices
  localparam tone_t TONE_NEG_DISARMED   = 4'd0;
  localparam tone_t TONE_NEG_ARMED      = 4'd1;
  localparam tone_t TONE_POS_DISARMED   = 4'd2;
  localparam tone_t TONE_POS_ARMED      = 4'd3;
  localparam tone_t TONE_RADIO_DISARMED = 4'd4;
  localparam tone_t TONE_RADIO_ARMED    = 4'd5;
  localparam tone_t TONE_MISSION_DONE   = 4'd6;
  localparam tone_t TONE_PREARM_OK      = 4'd7;
  localparam tone_t TONE_ALERT          = 4'd8;
  localparam tone_t TONE_ARMING         = 4'd9;
  localparam tone_t TONE_WAYPOINT       = 4'd10;
  localparam tone_t TONE_LOW_BATT       = 4'd13;
  localparam tone_t TONE_STOP           = 4'd14;
  localparam tone_t TONE_NONE           = 4'd15;

  // event bit positions
  localparam int EV_TUNE_DONE    = 0;
  localparam int EV_MISSION_DONE = 1;
  localparam int EV_TUNE_FAILED  = 2;
  localparam int EV_WAYPOINT     = 3;
  localparam int EV_MODE_OK      = 4;
  localparam int EV_MODE_FAILED  = 5;
  localparam int EV_FS_MODE      = 6;

  // seen flag positions
  localparam int FL_ARMED  = 0;
  localparam int FL_BATT   = 1;
  localparam int FL_RADIO  = 2;
  localparam int FL_AFAIL  = 3;
  localparam int FL_PREARM = 4;
  localparam int FL_CHUTE  = 5;

  // result slots, in rule order
  localparam int NUM_SLOTS     = 14;
  localparam int SLOT_W        = $clog2(NUM_SLOTS);
  localparam int SLOT_RESUME   = 0;
  localparam int SLOT_MISSION  = 1;
  localparam int SLOT_TFAIL    = 2;
  localparam int SLOT_WAYPOINT = 3;
  localparam int SLOT_MODE_OK  = 4;
  localparam int SLOT_MODE_BAD = 5;
  localparam int SLOT_FS_MODE  = 6;
  localparam int SLOT_AFAIL    = 7;
  localparam int SLOT_RADIO    = 8;
  localparam int SLOT_PREARM   = 9;
  localparam int SLOT_ARM      = 10;
  localparam int SLOT_STOP     = 11;
  localparam int SLOT_BATT     = 12;
  localparam int SLOT_CHUTE    = 13;

  localparam logic [15:0] MAX_TONE_RESET = 16'd2000;

  // one tick's worth of tones: a slot mask and the code in each slot
  typedef struct packed {
    logic [NUM_SLOTS-1:0]  mask;
    tone_t [NUM_SLOTS-1:0] codes;
  } run_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alert_tone_selector.sv -----
// channel   dir  handshake            payload
// in_       in   in_valid / in_stall  action, now_ms, six flags, event_bits
// out_      out  out_valid / out_stall tone_code, last_of_run
// cfg_      in   cfg_wr_en            cfg_wr_data (max_tone_ms)
//
// one input beat per cycle is taken while the run queue has room
// a tick that selects k tones gives k output beats on consecutive cycles while
// out_stall is low, the first one after the queue entry, the run register and
// the output register; the output register sets the rate at one tone per cycle
// while out_stall is low; init beats and ticks with no tone give no output beat
// reset is synchronous, active low; stall on the output only backs up the queue
`default_nettype none

`include "alert_tone_selector_defines.svh"

module alert_tone_selector import ats_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_armed,
  input  wire logic        in_battery_failsafe,
  input  wire logic        in_radio_failsafe,
  input  wire logic        in_arm_failed,
  input  wire logic        in_prearm_ok,
  input  wire logic        in_chute_released,
  input  wire logic [6:0]  in_event_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_tone_code,
  output logic             out_last_of_run,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic q_push;
  run_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  run_t q_head;

  // front: accept and classify
  ats_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_now_ms           (in_now_ms),
    .in_armed            (in_armed),
    .in_battery_failsafe (in_battery_failsafe),
    .in_radio_failsafe   (in_radio_failsafe),
    .in_arm_failed       (in_arm_failed),
    .in_prearm_ok        (in_prearm_ok),
    .in_chute_released   (in_chute_released),
    .in_event_bits       (in_event_bits),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_push_data         (q_push_data)
  );

  // run queue between the two sides
  ats_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: serialise each run into tone beats
  ats_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tone_code   (out_tone_code),
    .out_last_of_run (out_last_of_run)
  );

  // checks
  `ATS_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_full, "push into full queue")
  `ATS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  `ATS_ASSERT_IMP(a_push_nonempty, clk, rst_n, q_push, q_push_data.mask != '0, "empty run queued")
  `ATS_ASSERT_NXT(a_push_no_init, clk, rst_n, q_push && in_action == ACT_INIT, 1'b0, "init queued")
  `ATS_ASSERT_IMP(a_no_none_out, clk, rst_n, out_valid, out_tone_code != TONE_NONE, "none tone sent")

endmodule

`default_nettype wire

// ----- hw/rtl/ats_front.sv -----
`default_nettype none

module ats_front import ats_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_armed,
  input  wire logic        in_battery_failsafe,
  input  wire logic        in_radio_failsafe,
  input  wire logic        in_arm_failed,
  input  wire logic        in_prearm_ok,
  input  wire logic        in_chute_released,
  input  wire logic [6:0]  in_event_bits,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        q_full,
  output logic             q_push,
  output run_t             q_push_data
);

  logic [15:0] max_tone_r, max_tone_nxt;
  logic [5:0]  seen_r, seen_nxt;
  tone_t       cont_r, cont_nxt;
  tone_t       play_r, play_nxt;
  logic [31:0] start_r, start_nxt;

  logic                 accept;
  logic                 tick;
  logic [31:0]          elapsed;
  logic                 resume;
  logic                 radio_edge;
  logic                 arm_edge;
  logic [NUM_SLOTS-1:0] raw_mask;
  logic [NUM_SLOTS-1:0] mask;
  run_t                 run;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign tick     = (in_action == ACT_TICK);

  // interrupted continuous tone check, wrap-safe elapsed time
  assign elapsed = in_now_ms - start_r;
  assign resume  = (cont_r != TONE_NONE) && (play_r != cont_r) &&
                   (elapsed > {16'd0, max_tone_r});

  assign radio_edge = (in_radio_failsafe != seen_r[FL_RADIO]);
  assign arm_edge   = (in_armed != seen_r[FL_ARMED]);

  // classify the beat into fixed result slots
  always_comb begin
    raw_mask = '0;
    run      = '0;

    raw_mask[SLOT_RESUME]  = resume;
    run.codes[SLOT_RESUME] = cont_r;

    raw_mask[SLOT_MISSION]  = in_armed &&
      (in_event_bits[EV_TUNE_DONE] || in_event_bits[EV_MISSION_DONE]);
    run.codes[SLOT_MISSION] = TONE_MISSION_DONE;

    raw_mask[SLOT_TFAIL]  = in_armed && in_event_bits[EV_TUNE_FAILED];
    run.codes[SLOT_TFAIL] = TONE_NEG_ARMED;

    raw_mask[SLOT_WAYPOINT]  = in_event_bits[EV_WAYPOINT];
    run.codes[SLOT_WAYPOINT] = TONE_WAYPOINT;

    raw_mask[SLOT_MODE_OK]  = in_event_bits[EV_MODE_OK];
    run.codes[SLOT_MODE_OK] = in_armed ? TONE_POS_ARMED : TONE_POS_DISARMED;

    raw_mask[SLOT_MODE_BAD]  = in_event_bits[EV_MODE_FAILED];
    run.codes[SLOT_MODE_BAD] = in_armed ? TONE_NEG_ARMED : TONE_NEG_DISARMED;

    raw_mask[SLOT_FS_MODE]  = in_event_bits[EV_FS_MODE];
    run.codes[SLOT_FS_MODE] = TONE_ALERT;

    raw_mask[SLOT_AFAIL]  = (in_arm_failed != seen_r[FL_AFAIL]) && in_arm_failed;
    run.codes[SLOT_AFAIL] = TONE_NEG_DISARMED;

    // radio lost only sounds when disarmed, regained always sounds
    raw_mask[SLOT_RADIO]  = radio_edge && (!in_radio_failsafe || !in_armed);
    run.codes[SLOT_RADIO] = in_radio_failsafe ? TONE_NEG_DISARMED :
                            (in_armed ? TONE_RADIO_ARMED : TONE_RADIO_DISARMED);

    raw_mask[SLOT_PREARM]  = (in_prearm_ok != seen_r[FL_PREARM]) && in_prearm_ok;
    run.codes[SLOT_PREARM] = TONE_PREARM_OK;

    raw_mask[SLOT_ARM]  = arm_edge;
    run.codes[SLOT_ARM] = in_armed ? TONE_ARMING : TONE_POS_DISARMED;

    // on disarm the disarm tone is playing, so stop fires only if it is continuous
    raw_mask[SLOT_STOP]  = arm_edge && !in_armed && (cont_r == TONE_POS_DISARMED);
    run.codes[SLOT_STOP] = TONE_STOP;

    raw_mask[SLOT_BATT]  = (in_battery_failsafe != seen_r[FL_BATT]) &&
                           in_battery_failsafe;
    run.codes[SLOT_BATT] = TONE_LOW_BATT;

    raw_mask[SLOT_CHUTE]  = (in_chute_released != seen_r[FL_CHUTE]) &&
                            in_chute_released;
    run.codes[SLOT_CHUTE] = TONE_ALERT;

    mask     = tick ? raw_mask : '0;
    run.mask = mask;
  end

  assign q_push      = accept && (mask != '0);
  assign q_push_data = run;

  // state after the beat
  always_comb begin
    max_tone_nxt = cfg_wr_en ? cfg_wr_data : max_tone_r;
    seen_nxt     = seen_r;
    cont_nxt     = cont_r;
    play_nxt     = play_r;
    start_nxt    = start_r;
    if (accept) begin
      if (!tick) begin
        seen_nxt[FL_ARMED]  = in_armed;
        seen_nxt[FL_BATT]   = in_battery_failsafe;
        seen_nxt[FL_PREARM] = 1'b1;
        cont_nxt            = TONE_NONE;
      end else begin
        seen_nxt = {in_chute_released, in_prearm_ok, in_arm_failed,
                    in_radio_failsafe, in_battery_failsafe, in_armed};
        if (mask != '0) begin
          start_nxt = in_now_ms;
        end
        // last tone in slot order is the one left playing
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (mask[k]) begin
            play_nxt = (run.codes[k] == TONE_STOP) ? TONE_NONE : run.codes[k];
          end
        end
        if (mask[SLOT_BATT]) begin
          cont_nxt = TONE_LOW_BATT;
        end else if (mask[SLOT_ARM] && !in_armed) begin
          cont_nxt = TONE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tone_r <= MAX_TONE_RESET;
      seen_r     <= '0;
      cont_r     <= TONE_NONE;
      play_r     <= TONE_NONE;
      start_r    <= '0;
    end else begin
      max_tone_r <= max_tone_nxt;
      seen_r     <= seen_nxt;
      cont_r     <= cont_nxt;
      play_r     <= play_nxt;
      start_r    <= start_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ats_queue.sv -----
`default_nettype none

module ats_queue import ats_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire run_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output run_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ats_back.sv -----
`default_nettype none

module ats_back import ats_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire run_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output tone_t      out_tone_code,
  output logic       out_last_of_run
);

  logic [NUM_SLOTS-1:0]  mask_r, mask_nxt;
  tone_t [NUM_SLOTS-1:0] codes_r, codes_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tone_t                 out_code_r, out_code_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [SLOT_W-1:0]    sel_idx;
  logic [NUM_SLOTS-1:0] rest;
  logic                 adv;
  logic                 emit;

  // lowest pending slot goes out first
  always_comb begin
    sel_idx = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel_idx = SLOT_W'(k);
      end
    end
  end

  assign rest  = mask_r & (mask_r - 1'b1);
  assign adv   = !out_valid_r || !out_stall;
  assign emit  = adv && (mask_r != '0);
  assign q_pop = q_valid && ((mask_r == '0) || (emit && (rest == '0)));

  // run register and output register
  always_comb begin
    mask_nxt      = mask_r;
    codes_nxt     = codes_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (q_pop) begin
      mask_nxt  = q_head.mask;
      codes_nxt = q_head.codes;
    end else if (emit) begin
      mask_nxt = rest;
    end
    if (adv) begin
      out_valid_nxt = emit;
      out_code_nxt  = codes_r[sel_idx];
      out_last_nxt  = (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    codes_r    <= codes_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tone_code   = out_code_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ----- tb/alert_tone_selector_tb.sv -----
`default_nettype none

module alert_tone_selector_tb;
  import ats_pkg::*;

  // first of the continuous tones, the last one is the low battery tone
  localparam tone_t TONE_CONT_FIRST = 4'd11;
  // directed row whose results come from the predictor
  localparam int PREDICTED = -1;
  // cycles to let an item with no tone work through the pipe
  localparam int SETTLE_CYCLES = 24;
  // length of the long output hold-off
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic        armed;
    logic        batt;
    logic        radio;
    logic        afail;
    logic        prearm;
    logic        chute;
    logic [6:0]  events;
  } alert_beat_t;

  typedef struct {
    tone_t code;
    logic  last;
  } tone_beat_t;

  typedef struct {
    alert_beat_t beat;
    int          n_typed;
    tone_t       codes [0:3];
  } tone_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic        in_armed = 1'b0;
  logic        in_battery_failsafe = 1'b0;
  logic        in_radio_failsafe = 1'b0;
  logic        in_arm_failed = 1'b0;
  logic        in_prearm_ok = 1'b0;
  logic        in_chute_released = 1'b0;
  logic [6:0]  in_event_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_tone_code;
  logic        out_last_of_run;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  alert_tone_selector DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_now_ms           (in_now_ms),
    .in_armed            (in_armed),
    .in_battery_failsafe (in_battery_failsafe),
    .in_radio_failsafe   (in_radio_failsafe),
    .in_arm_failed       (in_arm_failed),
    .in_prearm_ok        (in_prearm_ok),
    .in_chute_released   (in_chute_released),
    .in_event_bits       (in_event_bits),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tone_code       (out_tone_code),
    .out_last_of_run     (out_last_of_run),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state, mirrors the block from reset
  logic [15:0] tone_limit_ms = MAX_TONE_RESET;
  logic [5:0]  flags_seen = '0;
  tone_t       cont_tone = TONE_NONE;
  tone_t       cur_tone = TONE_NONE;
  logic [31:0] cur_tone_start = '0;
  tone_t       tick_tones[$];

  tone_beat_t  tones_due[$];
  tone_row_t   directed_rows[$];
  int          mismatch_count = 0;

  // idling controls for the source and the sink process
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  bit          hold_req = 1'b0;

  // random stimulus world: a clock and flags that persist between ticks
  logic [31:0] world_now = '0;
  logic [5:0]  world_flags = '0;

  function automatic void sound(tone_t t, logic [31:0] now);
    if (t >= TONE_CONT_FIRST && t <= TONE_LOW_BATT) cont_tone = t;
    cur_tone = t;
    cur_tone_start = now;
    tick_tones.push_back(t);
  endfunction

  // updates one seen flag, true when it changed
  function automatic bit flag_moved(int b, logic v);
    if (flags_seen[b] == v) return 1'b0;
    flags_seen[b] = v;
    return 1'b1;
  endfunction

  // tones chosen by one beat, left in tick_tones
  function automatic void predict_tones(alert_beat_t b);
    tick_tones.delete();
    if (b.action == ACT_INIT) begin
      flags_seen[FL_ARMED] = b.armed;
      flags_seen[FL_BATT] = b.batt;
      flags_seen[FL_PREARM] = 1'b1;
      cont_tone = TONE_NONE;
      return;
    end
    // interrupted continuous tone resumes after the limit
    if (cont_tone != TONE_NONE && cur_tone != cont_tone &&
        (b.now_ms - cur_tone_start) > tone_limit_ms)
      sound(cont_tone, b.now_ms);
    // one-shot events
    if (b.armed && (b.events[EV_TUNE_DONE] || b.events[EV_MISSION_DONE]))
      sound(TONE_MISSION_DONE, b.now_ms);
    if (b.armed && b.events[EV_TUNE_FAILED]) sound(TONE_NEG_ARMED, b.now_ms);
    if (b.events[EV_WAYPOINT]) sound(TONE_WAYPOINT, b.now_ms);
    if (b.events[EV_MODE_OK])
      sound(b.armed ? TONE_POS_ARMED : TONE_POS_DISARMED, b.now_ms);
    if (b.events[EV_MODE_FAILED])
      sound(b.armed ? TONE_NEG_ARMED : TONE_NEG_DISARMED, b.now_ms);
    if (b.events[EV_FS_MODE]) sound(TONE_ALERT, b.now_ms);
    // flag edges
    if (flag_moved(FL_AFAIL, b.afail) && b.afail) sound(TONE_NEG_DISARMED, b.now_ms);
    if (flag_moved(FL_RADIO, b.radio)) begin
      if (b.radio) begin
        if (!b.armed) sound(TONE_NEG_DISARMED, b.now_ms);
      end else begin
        sound(b.armed ? TONE_RADIO_ARMED : TONE_RADIO_DISARMED, b.now_ms);
      end
    end
    if (flag_moved(FL_PREARM, b.prearm) && b.prearm) sound(TONE_PREARM_OK, b.now_ms);
    if (flag_moved(FL_ARMED, b.armed)) begin
      if (b.armed) begin
        sound(TONE_ARMING, b.now_ms);
      end else begin
        sound(TONE_POS_DISARMED, b.now_ms);
        if (cont_tone == cur_tone) begin
          tick_tones.push_back(TONE_STOP);
          cur_tone = TONE_NONE;
        end
        cont_tone = TONE_NONE;
      end
    end
    if (flag_moved(FL_BATT, b.batt) && b.batt) sound(TONE_LOW_BATT, b.now_ms);
    if (flag_moved(FL_CHUTE, b.chute) && b.chute) sound(TONE_ALERT, b.now_ms);
  endfunction

  function automatic void expect_run(tone_t codes[$]);
    tone_beat_t t;
    foreach (codes[k]) begin
      t.code = codes[k];
      t.last = (k == codes.size() - 1);
      tones_due.push_back(t);
    end
  endfunction

  // flags in seen order: chute, prearm, arm failed, radio, battery, armed
  function automatic void add_row(logic act, logic [31:0] now, logic [5:0] fl,
                                  logic [6:0] ev, int n, tone_t c0 = TONE_NONE,
                                  tone_t c1 = TONE_NONE, tone_t c2 = TONE_NONE,
                                  tone_t c3 = TONE_NONE);
    tone_row_t r;
    r.beat.action = act;
    r.beat.now_ms = now;
    r.beat.armed = fl[FL_ARMED];
    r.beat.batt = fl[FL_BATT];
    r.beat.radio = fl[FL_RADIO];
    r.beat.afail = fl[FL_AFAIL];
    r.beat.prearm = fl[FL_PREARM];
    r.beat.chute = fl[FL_CHUTE];
    r.beat.events = ev;
    r.n_typed = n;
    r.codes = '{c0, c1, c2, c3};
    directed_rows.push_back(r);
  endfunction

  // next random beat: mostly plausible ticks, some inits and noise
  function automatic alert_beat_t next_beat();
    alert_beat_t b;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      b = alert_beat_t'({$urandom, $urandom});
      return b;
    end
    if (roll < 12) begin
      b.action = ACT_INIT;
    end else begin
      b.action = ACT_TICK;
      roll = $urandom_range(0, 99);
      if (roll < 70) world_now = world_now + 32'd20;
      else if (roll < 90) world_now = world_now + $urandom_range(0, 3000);
      else if (roll < 98) world_now = world_now + $urandom_range(0, 70000);
      else world_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
      for (int f = 0; f < 6; f++)
        if ($urandom_range(0, 99) < 8) world_flags[f] = ~world_flags[f];
    end
    b.now_ms = world_now;
    b.armed = world_flags[FL_ARMED];
    b.batt = world_flags[FL_BATT];
    b.radio = world_flags[FL_RADIO];
    b.afail = world_flags[FL_AFAIL];
    b.prearm = world_flags[FL_PREARM];
    b.chute = world_flags[FL_CHUTE];
    roll = $urandom_range(0, 99);
    if (roll < 60) b.events = '0;
    else if (roll < 85) b.events = 7'd1 << $urandom_range(0, 6);
    else b.events = 7'($urandom_range(0, 127));
    return b;
  endfunction

  task automatic send_beat(alert_beat_t b);
    in_valid <= 1'b1;
    in_action <= b.action;
    in_now_ms <= b.now_ms;
    in_armed <= b.armed;
    in_battery_failsafe <= b.batt;
    in_radio_failsafe <= b.radio;
    in_arm_failed <= b.afail;
    in_prearm_ok <= b.prearm;
    in_chute_released <= b.chute;
    in_event_bits <= b.events;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic source_gap();
    int n;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender pauses until every tone has come out and the pipe is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tones_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tone_limit_ms = v;
  endtask

  task automatic run_phase(logic [15:0] limit, int n, int src_pct, int sink_pct,
                           bit squeeze);
    alert_beat_t b;
    int burst;
    wait_idle();
    write_limit(limit);
    sink_idle_pct = sink_pct;
    src_idle_pct = src_pct;
    burst = 0;
    // long output hold-off while beats keep coming back to back
    if (squeeze) begin
      hold_req = 1'b1;
      burst = 30;
      for (int i = 0; i < burst; i++) begin
        b = next_beat();
        b.action = ACT_TICK;
        b.events[EV_WAYPOINT] = 1'b1;
        predict_tones(b);
        expect_run(tick_tones);
        send_beat(b);
      end
    end
    for (int i = burst; i < n; i++) begin
      b = next_beat();
      predict_tones(b);
      expect_run(tick_tones);
      send_beat(b);
      source_gap();
    end
  endtask

  task automatic report_mismatch(string what, tone_beat_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected tone %0d last %0b, got tone %0d last %0b",
               $realtime, what, want.code, want.last, out_tone_code, out_last_of_run);
  endtask

  // output checker, sampled at the edge
  always @(posedge clk) begin
    tone_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tones_due.size() == 0) begin
        want.code = TONE_NONE;
        want.last = 1'b0;
        report_mismatch("unexpected tone beat", want);
      end else begin
        want = tones_due.pop_front();
        if (out_tone_code !== want.code || out_last_of_run !== want.last)
          report_mismatch("tone beat mismatch", want);
      end
    end
  end

  // output stall: random gaps, plus one long hold-off on request
  initial begin
    int roll;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        out_stall <= 1'b1;
        roll = $urandom_range(0, 9);
        if (roll == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // overall time limit
  initial begin
    #30000000;
    $display("alert_tone_selector_tb: errors");
    $finish;
  end

  initial begin
    tone_t typed[$];
    tone_row_t r;

    // directed table
    add_row(ACT_TICK, 32'd0, 6'b000000, 7'h00, 0);
    add_row(ACT_INIT, 32'd0, 6'b000000, 7'h00, 0);
    add_row(ACT_TICK, 32'd100, 6'b010000, 7'h7F, 4,
            TONE_WAYPOINT, TONE_POS_DISARMED, TONE_NEG_DISARMED, TONE_ALERT);
    add_row(ACT_TICK, 32'd200, 6'b010001, 7'h00, 1, TONE_ARMING);
    add_row(ACT_TICK, 32'd300, 6'b010001, 7'h7F, PREDICTED);
    add_row(ACT_TICK, 32'd400, 6'b010011, 7'h00, 1, TONE_LOW_BATT);
    add_row(ACT_TICK, 32'd500, 6'b010011, 7'h08, 1, TONE_WAYPOINT);
    // limit reached exactly, then passed by one
    add_row(ACT_TICK, 32'd2500, 6'b010011, 7'h00, 0);
    add_row(ACT_TICK, 32'd2501, 6'b010011, 7'h00, 1, TONE_LOW_BATT);
    add_row(ACT_TICK, 32'd2600, 6'b010011, 7'h08, 1, TONE_WAYPOINT);
    // disarm while interrupted: no stop command
    add_row(ACT_TICK, 32'd2700, 6'b010010, 7'h00, 1, TONE_POS_DISARMED);
    add_row(ACT_TICK, 32'd2800, 6'b010001, 7'h00, 1, TONE_ARMING);
    add_row(ACT_TICK, 32'd2900, 6'b010011, 7'h00, 1, TONE_LOW_BATT);
    // elapsed time across the clock wrap
    add_row(ACT_TICK, 32'hFFFF_FF00, 6'b010011, 7'h08, 1, TONE_WAYPOINT);
    add_row(ACT_TICK, 32'h0000_0800, 6'b010011, 7'h00, 1, TONE_LOW_BATT);
    add_row(ACT_TICK, 32'h0000_0900, 6'b010111, 7'h00, 0);
    add_row(ACT_TICK, 32'h0000_0A00, 6'b010011, 7'h00, 1, TONE_RADIO_ARMED);
    add_row(ACT_TICK, 32'h0000_0B00, 6'b111110, 7'h00, 4,
            TONE_NEG_DISARMED, TONE_NEG_DISARMED, TONE_POS_DISARMED, TONE_ALERT);
    add_row(ACT_TICK, 32'h0000_0C00, 6'b000000, 7'h00, 1, TONE_RADIO_DISARMED);
    add_row(ACT_TICK, 32'h0000_0D00, 6'b010000, 7'h00, 1, TONE_PREARM_OK);
    add_row(ACT_INIT, 32'h0000_0E00, 6'b000011, 7'h00, 0);
    add_row(ACT_TICK, 32'hFFFF_FFFF, 6'b010011, 7'h7F, PREDICTED);
    add_row(ACT_TICK, 32'hFFFF_FFFF, 6'b111111, 7'h7F, PREDICTED);
    add_row(ACT_TICK, 32'd0, 6'b000000, 7'h00, PREDICTED);

    // reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    src_idle_pct = 20;
    sink_idle_pct = 20;
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      predict_tones(r.beat);
      if (r.n_typed == PREDICTED) begin
        expect_run(tick_tones);
      end else begin
        typed.delete();
        for (int k = 0; k < r.n_typed; k++) typed.push_back(r.codes[k]);
        expect_run(typed);
      end
      send_beat(r.beat);
      source_gap();
    end

    // random phases over several limits
    run_phase(16'd0, 92, 0, 0, 1'b0);
    run_phase(16'hFFFF, 92, 30, 30, 1'b0);
    run_phase(16'($urandom_range(1, 5000)), 92, 10, 50, 1'b1);
    run_phase(16'd1, 92, 50, 10, 1'b0);
    run_phase(MAX_TONE_RESET, 92, 25, 25, 1'b0);

    wait_idle();
    if (mismatch_count == 0 && tones_due.size() == 0) begin
      $display("alert_tone_selector_tb: clean");
    end else begin
      $display("alert_tone_selector_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
